[hdl/nca_pkg.sv]
`timescale 1ns / 1ps
// shared constants and types for the nearest centroid assignment block
package nca_pkg;

   localparam int NUM_GROUPS_DEF = 16;
   localparam int NUM_DIMS_DEF   = 64;
   localparam int COORD_BITS_DEF = 16;

   localparam int DIST_BITS     = 38;
   localparam int SQ_LIMIT_BITS = 19;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef struct packed {
      logic valid;
      logic func;
      logic last;
   } item_ctl_type;

endpackage

[hdl/nca_cell.sv]
`timescale 1ns / 1ps
// one chain cell: centroid slice, squared distance accumulator and running minimum
module nca_cell #(
   parameter int NUM_GROUPS = nca_pkg::NUM_GROUPS_DEF,
   parameter int NUM_DIMS   = nca_pkg::NUM_DIMS_DEF,
   parameter int COORD_BITS = nca_pkg::COORD_BITS_DEF,
   parameter int GROUP_BITS = $clog2(NUM_GROUPS),
   parameter int DIM_BITS   = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1,
   parameter int CNT_BITS   = $clog2(NUM_GROUPS + 1),
   parameter int CELL_INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic [CNT_BITS-1:0]                 n_act,
   input  nca_pkg::item_ctl_type               in_ctl,
   input  logic [GROUP_BITS-1:0]               in_group,
   input  logic [DIM_BITS-1:0]                 in_dim,
   input  logic signed [COORD_BITS-1:0]        in_coord,
   output nca_pkg::item_ctl_type               out_ctl,
   output logic [GROUP_BITS-1:0]               out_group,
   output logic [DIM_BITS-1:0]                 out_dim,
   output logic signed [COORD_BITS-1:0]        out_coord,
   input  logic [GROUP_BITS-1:0]               tok_in_group,
   input  logic [nca_pkg::DIST_BITS-1:0]       tok_in_dist,
   output logic                                tok_out_vld,
   output logic [GROUP_BITS-1:0]               tok_out_group,
   output logic [nca_pkg::DIST_BITS-1:0]       tok_out_dist
);

   localparam int DB      = nca_pkg::DIST_BITS;
   localparam int LB      = nca_pkg::SQ_LIMIT_BITS;
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int MW      = (DIFF_W > LB + 1) ? DIFF_W : LB + 1;
   localparam bit FIRST   = (CELL_INDEX == 0);

   nca_pkg::item_ctl_type          ctl_ff;
   logic [GROUP_BITS-1:0]          group_ff;
   logic [DIM_BITS-1:0]            dim_ff;
   logic signed [COORD_BITS-1:0]   coord_ff;

   logic signed [COORD_BITS-1:0]   mem [NUM_DIMS];
   logic signed [COORD_BITS-1:0]   rd_ff;

   logic                           active;
   logic                           dim_ok;
   logic                           wr_en;

   logic                           b_acc_ff, b_acc_in;
   logic                           b_end_ff, b_end_in;
   logic signed [COORD_BITS-1:0]   b_coord_ff;

   logic signed [DIFF_W-1:0]       diff;
   logic [DIFF_W-1:0]              mag;
   logic [MW-1:0]                  mag_ff, mag_in;
   logic                           m_acc_ff, m_end_ff;

   logic                           over;
   logic [DB-1:0]                  prod;
   logic [DB-1:0]                  sq_ff, sq_in;
   logic                           s_acc_ff, s_end_ff;

   logic [DB:0]                    sum;
   logic [DB-1:0]                  acc_sat;
   logic [DB-1:0]                  acc_ff, acc_in;
   logic [DB-1:0]                  fin_ff;
   logic                           c_end_ff;

   logic                           take_own;

   assign active = CNT_BITS'(CELL_INDEX) < n_act;
   assign dim_ok = (DIM_BITS + 1)'(dim_ff) < (DIM_BITS + 1)'(NUM_DIMS);
   assign wr_en  = ctl_ff.valid && (ctl_ff.func == nca_pkg::FUNC_LOAD) &&
                   (group_ff == GROUP_BITS'(CELL_INDEX)) && dim_ok;

   // item register, handed to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         group_ff <= in_group;
         dim_ff   <= in_dim;
         coord_ff <= in_coord;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_group = group_ff;
   assign out_dim   = dim_ff;
   assign out_coord = coord_ff;

   // centroid slice
   always_ff @(posedge clock) begin
      if (adv) begin
         if (wr_en) begin
            mem[dim_ff] <= coord_ff;
         end
         rd_ff <= mem[dim_ff];
      end
   end

   assign b_acc_in = ctl_ff.valid && (ctl_ff.func == nca_pkg::FUNC_SAMPLE) && dim_ok && active;
   assign b_end_in = ctl_ff.valid && (ctl_ff.func == nca_pkg::FUNC_SAMPLE) && ctl_ff.last;

   // difference magnitude
   assign diff   = DIFF_W'(b_coord_ff) - DIFF_W'(rd_ff);
   assign mag    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
   assign mag_in = MW'(mag);

   // square, saturating
   assign over  = |mag_ff[MW-1:LB];
   assign prod  = mag_ff[LB-1:0] * mag_ff[LB-1:0];
   assign sq_in = over ? nca_pkg::DIST_MAX : prod;

   // accumulate, saturating
   assign sum     = {1'b0, acc_ff} + {1'b0, sq_ff};
   assign acc_sat = sum[DB] ? nca_pkg::DIST_MAX : sum[DB-1:0];
   assign acc_in  = s_acc_ff ? acc_sat : acc_ff;

   // running minimum, lowest index wins ties
   assign take_own = active && (FIRST || (fin_ff < tok_in_dist));

   always_ff @(posedge clock) begin
      if (reset) begin
         b_acc_ff    <= 1'b0;
         b_end_ff    <= 1'b0;
         m_acc_ff    <= 1'b0;
         m_end_ff    <= 1'b0;
         s_acc_ff    <= 1'b0;
         s_end_ff    <= 1'b0;
         c_end_ff    <= 1'b0;
         acc_ff      <= '0;
         tok_out_vld <= 1'b0;
      end else if (adv) begin
         b_acc_ff    <= b_acc_in;
         b_end_ff    <= b_end_in;
         m_acc_ff    <= b_acc_ff;
         m_end_ff    <= b_end_ff;
         s_acc_ff    <= m_acc_ff;
         s_end_ff    <= m_end_ff;
         c_end_ff    <= s_end_ff;
         acc_ff      <= s_end_ff ? '0 : acc_in;
         tok_out_vld <= c_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_coord_ff    <= coord_ff;
         mag_ff        <= mag_in;
         sq_ff         <= sq_in;
         fin_ff        <= acc_in;
         tok_out_group <= take_own ? GROUP_BITS'(CELL_INDEX) : tok_in_group;
         tok_out_dist  <= take_own ? fin_ff : tok_in_dist;
      end
   end

endmodule

[hdl/nearest_centroid_assign_top.sv]
`timescale 1ns / 1ps
// top level: chain of centroid cells with config register and result register
// throughput: one beat per cycle, set by the chain advancing one cell per cycle
// the chain holds only while a result waits at its tail and the result register is stalled
// reset clears control state and accumulators and sets active_groups to NUM_GROUPS
// centroid memories are not cleared and hold nothing defined until loaded
module nearest_centroid_assign_top #(
   parameter int NUM_GROUPS = nca_pkg::NUM_GROUPS_DEF,
   parameter int NUM_DIMS   = nca_pkg::NUM_DIMS_DEF,
   parameter int COORD_BITS = nca_pkg::COORD_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic                                        req_func,
   input  logic [$clog2(NUM_GROUPS)-1:0]               req_group_index,
   input  logic [((NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1)-1:0] req_dim_index,
   input  logic signed [COORD_BITS-1:0]                req_coord_value,
   input  logic                                        req_last_coord,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [$clog2(NUM_GROUPS)-1:0]               rsp_nearest_group,
   output logic [nca_pkg::DIST_BITS-1:0]               rsp_nearest_dist_sq,
   input  logic                                        csr_write_enable,
   input  logic [$clog2(NUM_GROUPS + 1)-1:0]           csr_active_groups
);

   localparam int GROUP_BITS = $clog2(NUM_GROUPS);
   localparam int DIM_BITS   = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
   localparam int CNT_BITS   = $clog2(NUM_GROUPS + 1);
   localparam int DB         = nca_pkg::DIST_BITS;

   logic [CNT_BITS-1:0]            n_act_ff, n_act_in;
   logic                           adv;
   logic                           tail_vld;
   logic                           rsp_valid_ff;
   logic [GROUP_BITS-1:0]          rsp_group_ff;
   logic [DB-1:0]                  rsp_dist_ff;

   nca_pkg::item_ctl_type          ctl_w   [NUM_GROUPS+1];
   logic [GROUP_BITS-1:0]          group_w [NUM_GROUPS+1];
   logic [DIM_BITS-1:0]            dim_w   [NUM_GROUPS+1];
   logic signed [COORD_BITS-1:0]   coord_w [NUM_GROUPS+1];
   logic [GROUP_BITS-1:0]          tok_group_w [NUM_GROUPS+1];
   logic [DB-1:0]                  tok_dist_w  [NUM_GROUPS+1];
   logic                           tok_vld_w   [NUM_GROUPS];

   // active count, clamped to 1..NUM_GROUPS
   always_comb begin
      if (csr_active_groups == '0) begin
         n_act_in = CNT_BITS'(1);
      end else if (csr_active_groups > CNT_BITS'(NUM_GROUPS)) begin
         n_act_in = CNT_BITS'(NUM_GROUPS);
      end else begin
         n_act_in = csr_active_groups;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_act_ff <= CNT_BITS'(NUM_GROUPS);
      end else if (csr_write_enable) begin
         n_act_ff <= n_act_in;
      end
   end

   assign tail_vld  = tok_vld_w[NUM_GROUPS-1];
   assign adv       = !(tail_vld && rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   assign ctl_w[0].valid = req_valid;
   assign ctl_w[0].func  = req_func;
   assign ctl_w[0].last  = req_last_coord;
   assign group_w[0]     = req_group_index;
   assign dim_w[0]       = req_dim_index;
   assign coord_w[0]     = req_coord_value;
   assign tok_group_w[0] = '0;
   assign tok_dist_w[0]  = '0;

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_cell
      nca_cell #(
         .NUM_GROUPS (NUM_GROUPS),
         .NUM_DIMS   (NUM_DIMS),
         .COORD_BITS (COORD_BITS),
         .GROUP_BITS (GROUP_BITS),
         .DIM_BITS   (DIM_BITS),
         .CNT_BITS   (CNT_BITS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .adv           (adv),
         .n_act         (n_act_ff),
         .in_ctl        (ctl_w[g]),
         .in_group      (group_w[g]),
         .in_dim        (dim_w[g]),
         .in_coord      (coord_w[g]),
         .out_ctl       (ctl_w[g+1]),
         .out_group     (group_w[g+1]),
         .out_dim       (dim_w[g+1]),
         .out_coord     (coord_w[g+1]),
         .tok_in_group  (tok_group_w[g]),
         .tok_in_dist   (tok_dist_w[g]),
         .tok_out_vld   (tok_vld_w[g]),
         .tok_out_group (tok_group_w[g+1]),
         .tok_out_dist  (tok_dist_w[g+1])
      );
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && tail_vld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tail_vld) begin
         rsp_group_ff <= tok_group_w[NUM_GROUPS];
         rsp_dist_ff  <= tok_dist_w[NUM_GROUPS];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_nearest_group   = rsp_group_ff;
   assign rsp_nearest_dist_sq = rsp_dist_ff;

`ifndef SYNTHESIS
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && tail_vld))
      else $error("input stalled without a blocked result");

   a_tail_held: assert property (@(posedge clock) disable iff (reset)
      (tail_vld && rsp_valid && rsp_stall) |=> tail_vld)
      else $error("pending result lost at chain tail");

   a_tail_loads_output: assert property (@(posedge clock) disable iff (reset)
      (tail_vld && adv) |=> rsp_valid)
      else $error("chain result did not reach result register");

   a_rsp_dropped_only_when_taken: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("result beat dropped while stalled");
`endif

endmodule

[tb/nearest_centroid_assign_top_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for nearest_centroid_assign_top with a distance scoreboard
module nearest_centroid_assign_top_tb;

   localparam int GROUPS          = nca_pkg::NUM_GROUPS_DEF;
   localparam int DIMS            = nca_pkg::NUM_DIMS_DEF;
   localparam int SETTLE_CYCLES   = GROUPS + 15;
   localparam int HOLD_CYCLES     = 120;
   localparam int ITEMS_PER_PHASE = 275;
   localparam int NUM_PHASES      = 6;

   typedef logic signed [nca_pkg::COORD_BITS_DEF-1:0] coord_type;
   typedef logic [nca_pkg::DIST_BITS-1:0]             dist_type;
   typedef logic [$clog2(GROUPS)-1:0]                 group_type;
   typedef logic [$clog2(DIMS)-1:0]                   dim_type;
   typedef logic [$clog2(GROUPS + 1)-1:0]             active_type;

   localparam coord_type COORD_MIN = {1'b1, {(nca_pkg::COORD_BITS_DEF-1){1'b0}}};
   localparam coord_type COORD_MAX = {1'b0, {(nca_pkg::COORD_BITS_DEF-1){1'b1}}};

   typedef struct packed {
      group_type nearest_group;
      dist_type  nearest_dist_sq;
   } nearest_type;

   class nearest_scoreboard;
      coord_type   centroid [GROUPS][DIMS];
      dist_type    dist_acc [GROUPS];
      int          active_count;
      nearest_type pending_nearest [$];
      int          errors;

      function new();
         active_count = GROUPS;
         errors = 0;
         foreach (dist_acc[g]) dist_acc[g] = '0;
         foreach (centroid[g, d]) centroid[g][d] = '0;
      endfunction

      function void set_active(active_type value);
         if (value == 0) active_count = 1;
         else if (value > GROUPS) active_count = GROUPS;
         else active_count = value;
      endfunction

      function dist_type square_diff(coord_type a, coord_type b);
         int diff;
         longint unsigned mag;
         diff = int'(a) - int'(b);
         mag = (diff < 0) ? longint'(-diff) : longint'(diff);
         if (mag >= (64'd1 << nca_pkg::SQ_LIMIT_BITS)) return nca_pkg::DIST_MAX;
         return dist_type'(mag * mag);
      endfunction

      function void note_beat(logic func, group_type grp, dim_type dim, coord_type coord,
                              logic last);
         longint unsigned sum;
         nearest_type best;
         int g;
         if (func == nca_pkg::FUNC_LOAD) begin
            centroid[grp][dim] = coord;
            return;
         end
         for (g = 0; g < active_count; g++) begin
            sum = longint'(dist_acc[g]) + longint'(square_diff(coord, centroid[g][dim]));
            dist_acc[g] = (sum > nca_pkg::DIST_MAX) ? nca_pkg::DIST_MAX : dist_type'(sum);
         end
         if (!last) return;
         best.nearest_group   = '0;
         best.nearest_dist_sq = dist_acc[0];
         for (g = 1; g < active_count; g++) begin
            if (dist_acc[g] < best.nearest_dist_sq) begin
               best.nearest_group   = group_type'(g);
               best.nearest_dist_sq = dist_acc[g];
            end
         end
         foreach (dist_acc[i]) dist_acc[i] = '0;
         pending_nearest.push_back(best);
      endfunction

      function void check_result(group_type grp, dist_type got_dist);
         nearest_type want;
         if (pending_nearest.size() == 0) begin
            $error("unexpected result beat: nearest_group %0d, nearest_dist_sq %0d",
                   grp, got_dist);
            errors++;
            return;
         end
         want = pending_nearest.pop_front();
         if (grp !== want.nearest_group) begin
            $error("nearest_group mismatch: expected %0d, actual %0d",
                   want.nearest_group, grp);
            errors++;
         end
         if (got_dist !== want.nearest_dist_sq) begin
            $error("nearest_dist_sq mismatch: expected %0d, actual %0d",
                   want.nearest_dist_sq, got_dist);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_func = nca_pkg::FUNC_LOAD;
   group_type  req_group_index = '0;
   dim_type    req_dim_index = '0;
   coord_type  req_coord_value = '0;
   logic       req_last_coord = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   group_type  rsp_nearest_group;
   dist_type   rsp_nearest_dist_sq;
   logic       csr_write_enable = 1'b0;
   active_type csr_active_groups = active_type'(GROUPS);

   nearest_scoreboard nearest_sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 1'b0;
   bit row_loaded [GROUPS][DIMS];
   bit row_ready [DIMS];
   dim_type ready_dims [$];

   nearest_centroid_assign_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_group_index     (req_group_index),
      .req_dim_index       (req_dim_index),
      .req_coord_value     (req_coord_value),
      .req_last_coord      (req_last_coord),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_nearest_group   (rsp_nearest_group),
      .rsp_nearest_dist_sq (rsp_nearest_dist_sq),
      .csr_write_enable    (csr_write_enable),
      .csr_active_groups   (csr_active_groups)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[nearest_centroid_assign_top] ERROR");
      $finish;
   end

   // result side: check beats, random stall, long hold on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            nearest_sb.check_result(rsp_nearest_group, rsp_nearest_dist_sq);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
         end
      end
   end

   task automatic send_beat(logic func, group_type grp, dim_type dim, coord_type coord,
                            logic last);
      bit full;
      int g;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_group_index <= grp;
      req_dim_index   <= dim;
      req_coord_value <= coord;
      req_last_coord  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      nearest_sb.note_beat(func, grp, dim, coord, last);
      if (func == nca_pkg::FUNC_LOAD) begin
         row_loaded[grp][dim] = 1'b1;
         full = 1'b1;
         for (g = 0; g < GROUPS; g++) full &= row_loaded[g][dim];
         if (full && !row_ready[dim]) begin
            row_ready[dim] = 1'b1;
            ready_dims.push_back(dim);
         end
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (nearest_sb.pending_nearest.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(active_type value);
      csr_write_enable  <= 1'b1;
      csr_active_groups <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      nearest_sb.set_active(value);
   endtask

   function automatic coord_type pick_coord(dim_type dim, int target);
      int pick;
      int v;
      pick = $urandom_range(99, 0);
      if (pick < 15) return nearest_sb.centroid[target][dim];
      if (pick < 60) begin
         v = int'(nearest_sb.centroid[target][dim]) + int'($urandom_range(128, 0)) - 64;
         if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
         if (v < int'(COORD_MIN)) v = int'(COORD_MIN);
         return coord_type'(v);
      end
      if (pick < 75) return $urandom_range(1, 0) ? COORD_MAX : COORD_MIN;
      return coord_type'($urandom());
   endfunction

   // sample beats only touch rows loaded for every group
   task automatic send_vector(int len);
      int target;
      int k;
      dim_type dim;
      target = $urandom_range(nearest_sb.active_count - 1, 0);
      for (k = 0; k < len; k++) begin
         dim = ready_dims[$urandom_range(ready_dims.size() - 1, 0)];
         send_beat(nca_pkg::FUNC_SAMPLE, group_type'($urandom()), dim,
                   pick_coord(dim, target), k == len - 1);
      end
   endtask

   // dim 0 holds the most negative value in every group, so this drives all sums to the cap
   task automatic send_saturating(int len);
      int k;
      for (k = 0; k < len; k++)
         send_beat(nca_pkg::FUNC_SAMPLE, group_type'($urandom()), '0, COORD_MAX,
                   k == len - 1);
   endtask

   task automatic load_row();
      dim_type dim;
      coord_type value;
      int g;
      dim = dim_type'($urandom_range(DIMS - 1, 1));
      value = coord_type'($urandom());
      for (g = 0; g < GROUPS; g++) begin
         // repeated values give distance ties
         if ($urandom_range(99, 0) >= 30) value = coord_type'($urandom());
         send_beat(nca_pkg::FUNC_LOAD, group_type'(g), dim, value,
                   1'($urandom_range(1, 0)));
      end
   endtask

   task automatic run_random(int count);
      int sent;
      int pick;
      int len;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99, 0);
         if (pick < 18) begin
            load_row();
            sent += GROUPS;
         end else if (pick < 28) begin
            send_beat(nca_pkg::FUNC_LOAD, group_type'($urandom()),
                      dim_type'($urandom_range(DIMS - 1, 1)),
                      coord_type'($urandom()), 1'($urandom_range(1, 0)));
            sent++;
         end else if (pick < 30) begin
            len = $urandom_range(72, 66);
            send_saturating(len);
            sent += len;
         end else begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 7) : $urandom_range(6, 1);
            send_vector(len);
            sent += len;
         end
      end
   endtask

   initial begin
      int ph;
      int g;
      active_type value;
      active_type phase_active [NUM_PHASES];
      phase_active = '{active_type'(1), active_type'(0), active_type'(31), active_type'(8),
                       active_type'(17), active_type'(GROUPS)};
      nearest_sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (g = 0; g < GROUPS; g++)
         send_beat(nca_pkg::FUNC_LOAD, group_type'(g), '0, COORD_MIN, logic'(g % 2));
      send_beat(nca_pkg::FUNC_LOAD, group_type'(GROUPS - 1), dim_type'(DIMS - 1), COORD_MAX,
                1'b1);
      // every group matches exactly, lowest index wins
      send_beat(nca_pkg::FUNC_SAMPLE, '0, '0, COORD_MIN, 1'b1);
      // widest difference, twice
      send_beat(nca_pkg::FUNC_SAMPLE, '1, '0, COORD_MAX, 1'b0);
      send_beat(nca_pkg::FUNC_SAMPLE, '1, '0, COORD_MAX, 1'b1);
      send_beat(nca_pkg::FUNC_SAMPLE, '0, '0, '0, 1'b1);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_quiet();
         send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 62 : 0;
         recv_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 27 : 0;
         value = phase_active[ph];
         if (ph == 3) value = active_type'($urandom_range(GROUPS - 1, 2));
         write_active(value);
         if (ph == NUM_PHASES - 1) hold_request = 1'b1;
         run_random(ITEMS_PER_PHASE);
      end
      wait_quiet();

      if (nearest_sb.errors == 0 && nearest_sb.pending_nearest.size() == 0) begin
         $display("[nearest_centroid_assign_top] OK");
      end else begin
         $display("[nearest_centroid_assign_top] ERROR");
      end
      $finish;
   end

endmodule
